// ----- hdl/tsd_pkg.sv -----
package tsd_pkg;

	// fixed tar geometry
	localparam int BLOCK_BYTES      = 512;
	localparam int SIZE_FIELD_BYTES = 12;
	localparam int QUEUE_DEPTH      = 4;

	localparam int POS_W   = 9;
	localparam int SIZE_W  = 36;
	localparam int FILES_W = 20;
	localparam int BYTES_W = 40;
	localparam int KIND_W  = 3;

	localparam logic [POS_W-1:0] OFS_SIZE     = 9'd124;
	localparam logic [POS_W-1:0] OFS_SIZE_END = POS_W'(124 + SIZE_FIELD_BYTES);
	localparam logic [POS_W-1:0] OFS_TYPE     = 9'd156;
	localparam logic [POS_W-1:0] OFS_PREFIX   = 9'd345;
	localparam logic [POS_W-1:0] POS_LAST     = POS_W'(BLOCK_BYTES - 1);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_SEVEN = 8'h37;

	// parser phases
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_DATA   = 2'd1;
	localparam logic [1:0] PH_PAD    = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	// octal size scan
	localparam logic [1:0] SCAN_NONE   = 2'd0;
	localparam logic [1:0] SCAN_DIGITS = 2'd1;
	localparam logic [1:0] SCAN_OVER   = 2'd2;

	// header flag bit positions
	localparam int FL_NONZERO = 0;
	localparam int FL_NAME    = 1;
	localparam int FL_PREFIX  = 2;
	localparam int FL_REGULAR = 3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DONE    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_TRUNC   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NOENT   = 3'd4;

	// one queue entry: everything one input byte produces (up to two events)
	typedef struct packed {
		logic               prim_valid;
		logic [KIND_W-1:0]  prim_kind;
		logic [7:0]         prim_byte;
		logic               prim_first;
		logic               prim_last;
		logic [SIZE_W-1:0]  prim_size;
		logic [FILES_W-1:0] prim_files;
		logic [BYTES_W-1:0] prim_bytes;
		logic               fin_valid;
		logic [KIND_W-1:0]  fin_kind;
		logic [FILES_W-1:0] fin_files;
		logic [BYTES_W-1:0] fin_bytes;
	} rec_t;

	typedef struct packed {
		logic push;
		rec_t rec;
	} push_t;

	typedef struct packed {
		logic empty;
		rec_t head;
	} q_view_t;

endpackage

// ----- hdl/tsd_front.sv -----
// Parser: one byte per accepted transfer, all state updated in that cycle.
module tsd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              stream_end,
	output tsd_pkg::push_t    push
);

	logic [1:0]                   phase_q;
	logic [tsd_pkg::POS_W-1:0]    pos_q;
	logic [tsd_pkg::SIZE_W-1:0]   acc_q;
	logic [1:0]                   scan_q;
	logic [3:0]                   flags_q;
	logic [tsd_pkg::SIZE_W-1:0]   drem_q;
	logic [tsd_pkg::POS_W-1:0]    pad_q;
	logic                         reg_q;
	logic [tsd_pkg::FILES_W-1:0]  files_q;
	logic [tsd_pkg::BYTES_W-1:0]  bytes_q;

	logic [1:0]                   ph_n;
	logic [tsd_pkg::POS_W-1:0]    pos_n;
	logic [tsd_pkg::SIZE_W-1:0]   acc_n;
	logic [1:0]                   scan_n;
	logic [3:0]                   flags_n;
	logic [tsd_pkg::SIZE_W-1:0]   drem_n;
	logic [tsd_pkg::POS_W-1:0]    pad_n;
	logic                         reg_n;
	logic [tsd_pkg::FILES_W-1:0]  files_n;
	logic [tsd_pkg::BYTES_W-1:0]  bytes_n;
	logic                         cnt;
	logic [tsd_pkg::SIZE_W-1:0]   cnt_size;
	logic [tsd_pkg::BYTES_W:0]    sum;
	logic                         hreg;
	logic                         in_size;
	logic                         is_octal;
	logic                         last;
	tsd_pkg::rec_t                rec;

	assign in_size  = (pos_q >= tsd_pkg::OFS_SIZE) && (pos_q < tsd_pkg::OFS_SIZE_END);
	assign is_octal = (data_byte >= tsd_pkg::CHAR_ZERO) && (data_byte <= tsd_pkg::CHAR_SEVEN);
	assign last     = (drem_q <= tsd_pkg::SIZE_W'(1));

	always_comb begin
		ph_n     = phase_q;
		pos_n    = pos_q;
		acc_n    = acc_q;
		scan_n   = scan_q;
		flags_n  = flags_q;
		drem_n   = drem_q;
		pad_n    = pad_q;
		reg_n    = reg_q;
		files_n  = files_q;
		bytes_n  = bytes_q;
		cnt      = 1'b0;
		cnt_size = '0;
		hreg     = 1'b0;
		sum      = '0;
		rec      = '0;

		case (phase_q)
			tsd_pkg::PH_HEADER: begin
				if (pos_q == '0) begin
					acc_n   = '0;
					scan_n  = tsd_pkg::SCAN_NONE;
					flags_n = '0;
				end
				if (data_byte != 8'h00) begin
					flags_n[tsd_pkg::FL_NONZERO] = 1'b1;
					if (pos_q == '0)
						flags_n[tsd_pkg::FL_NAME] = 1'b1;
					if (pos_q == tsd_pkg::OFS_PREFIX)
						flags_n[tsd_pkg::FL_PREFIX] = 1'b1;
				end
				if (pos_q == tsd_pkg::OFS_TYPE &&
				    (data_byte == 8'h00 || data_byte == tsd_pkg::CHAR_ZERO))
					flags_n[tsd_pkg::FL_REGULAR] = 1'b1;
				if (in_size && scan_n != tsd_pkg::SCAN_OVER) begin
					if (data_byte == 8'h00) begin
						scan_n = tsd_pkg::SCAN_OVER;
					end else if (is_octal) begin
						acc_n  = {acc_n[tsd_pkg::SIZE_W-4:0], data_byte[2:0]};
						scan_n = tsd_pkg::SCAN_DIGITS;
					end else if (scan_n == tsd_pkg::SCAN_DIGITS) begin
						scan_n = tsd_pkg::SCAN_OVER;
					end
				end
				if (pos_q == tsd_pkg::POS_LAST) begin
					pos_n = '0;
					if (!flags_n[tsd_pkg::FL_NONZERO]) begin
						// zero block ends the archive
						rec.fin_valid = 1'b1;
						rec.fin_kind  = (files_q != '0) ? tsd_pkg::KIND_DONE
						                                : tsd_pkg::KIND_NOENT;
						ph_n = tsd_pkg::PH_DONE;
					end else begin
						hreg  = (flags_n[tsd_pkg::FL_NAME] | flags_n[tsd_pkg::FL_PREFIX]) &
						        flags_n[tsd_pkg::FL_REGULAR];
						reg_n = hreg;
						if (hreg) begin
							rec.prim_valid = 1'b1;
							rec.prim_kind  = tsd_pkg::KIND_HEADER;
							rec.prim_size  = acc_n;
						end
						if (acc_n == '0) begin
							cnt = hreg;
						end else begin
							drem_n = acc_n;
							pad_n  = ~acc_n[tsd_pkg::POS_W-1:0] + tsd_pkg::POS_W'(1);
							ph_n   = tsd_pkg::PH_DATA;
						end
					end
				end else begin
					pos_n = pos_q + tsd_pkg::POS_W'(1);
				end
			end
			tsd_pkg::PH_DATA: begin
				if (reg_q) begin
					rec.prim_valid = 1'b1;
					rec.prim_kind  = tsd_pkg::KIND_PAYLOAD;
					rec.prim_byte  = data_byte;
					rec.prim_first = (drem_q == acc_q);
					rec.prim_last  = last;
				end
				if (last) begin
					drem_n   = '0;
					cnt      = reg_q;
					cnt_size = acc_q;
					pos_n    = '0;
					ph_n     = (pad_q != '0) ? tsd_pkg::PH_PAD : tsd_pkg::PH_HEADER;
				end else begin
					drem_n = drem_q - tsd_pkg::SIZE_W'(1);
				end
			end
			tsd_pkg::PH_PAD: begin
				if (pad_q <= tsd_pkg::POS_W'(1)) begin
					pad_n = '0;
					pos_n = '0;
					ph_n  = tsd_pkg::PH_HEADER;
				end else begin
					pad_n = pad_q - tsd_pkg::POS_W'(1);
				end
			end
			tsd_pkg::PH_DONE: begin
			end
			default: begin
			end
		endcase

		rec.prim_files = files_q;
		rec.prim_bytes = bytes_q;

		// saturating counts
		if (cnt) begin
			if (files_q != {tsd_pkg::FILES_W{1'b1}})
				files_n = files_q + tsd_pkg::FILES_W'(1);
			sum     = {1'b0, bytes_q} + (tsd_pkg::BYTES_W + 1)'(cnt_size);
			bytes_n = sum[tsd_pkg::BYTES_W] ? {tsd_pkg::BYTES_W{1'b1}}
			                                : sum[tsd_pkg::BYTES_W-1:0];
		end

		if (stream_end && ph_n != tsd_pkg::PH_DONE) begin
			rec.fin_valid = 1'b1;
			rec.fin_kind  = (ph_n == tsd_pkg::PH_DATA) ? tsd_pkg::KIND_TRUNC :
			                (files_n != '0) ? tsd_pkg::KIND_DONE : tsd_pkg::KIND_NOENT;
		end
		rec.fin_files = files_n;
		rec.fin_bytes = bytes_n;

		// stream end: back to the reset state for the next stream
		if (stream_end) begin
			ph_n    = tsd_pkg::PH_HEADER;
			pos_n   = '0;
			acc_n   = '0;
			scan_n  = tsd_pkg::SCAN_NONE;
			flags_n = '0;
			drem_n  = '0;
			pad_n   = '0;
			reg_n   = 1'b0;
			files_n = '0;
			bytes_n = '0;
		end
	end

	assign push.push = accept && (rec.prim_valid || rec.fin_valid);
	assign push.rec  = rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tsd_pkg::PH_HEADER;
			pos_q   <= '0;
			acc_q   <= '0;
			scan_q  <= tsd_pkg::SCAN_NONE;
			flags_q <= '0;
			drem_q  <= '0;
			pad_q   <= '0;
			reg_q   <= 1'b0;
			files_q <= '0;
			bytes_q <= '0;
		end else if (accept) begin
			phase_q <= ph_n;
			pos_q   <= pos_n;
			acc_q   <= acc_n;
			scan_q  <= scan_n;
			flags_q <= flags_n;
			drem_q  <= drem_n;
			pad_q   <= pad_n;
			reg_q   <= reg_n;
			files_q <= files_n;
			bytes_q <= bytes_n;
		end
	end

endmodule

// ----- hdl/tsd_queue.sv -----
// Small register queue of per-byte event records, head shown ahead.
module tsd_queue #(
	parameter int DEPTH = tsd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tsd_pkg::push_t   push,
	input  logic             pop,
	output logic             full,
	output tsd_pkg::q_view_t view
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tsd_pkg::rec_t    mem [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign view.empty = (count_q == '0);
	assign view.head  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push.push)
			mem[wr_q] <= push.rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			case ({push.push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/tsd_back.sv -----
// Output sequencer: expands each record into one or two events.
module tsd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tsd_pkg::q_view_t              view,
	output logic                          pop,
	output logic                          event_valid,
	input  logic                          event_stall,
	output logic [tsd_pkg::KIND_W-1:0]    kind,
	output logic [7:0]                    payload_byte,
	output logic                          entry_first,
	output logic                          entry_last,
	output logic [tsd_pkg::SIZE_W-1:0]    entry_size,
	output logic [tsd_pkg::FILES_W-1:0]   files_found,
	output logic [tsd_pkg::BYTES_W-1:0]   bytes_found,
	output logic                          run_last
);

	logic valid_q;
	logic half_q;   // primary event of the head record already sent
	logic load;
	logic take;
	logic send_prim;

	assign load      = !valid_q || !event_stall;
	assign take      = load && !view.empty;
	assign send_prim = view.head.prim_valid && !half_q;
	assign pop       = take && !(send_prim && view.head.fin_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
			half_q  <= send_prim && view.head.fin_valid;
		end else if (load) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (send_prim) begin
				kind         <= view.head.prim_kind;
				payload_byte <= view.head.prim_byte;
				entry_first  <= view.head.prim_first;
				entry_last   <= view.head.prim_last;
				entry_size   <= view.head.prim_size;
				files_found  <= view.head.prim_files;
				bytes_found  <= view.head.prim_bytes;
				run_last     <= !view.head.fin_valid;
			end else begin
				kind         <= view.head.fin_kind;
				payload_byte <= '0;
				entry_first  <= 1'b0;
				entry_last   <= 1'b0;
				entry_size   <= '0;
				files_found  <= view.head.fin_files;
				bytes_found  <= view.head.fin_bytes;
				run_last     <= 1'b1;
			end
		end
	end

	assign event_valid = valid_q;

endmodule

// ----- hdl/tar_stream_deframer.sv -----
// Channel | Dir | Handshake                 | Fields
// --------+-----+---------------------------+-----------------------------------------------
// byte    | in  | byte_valid / byte_stall   | data_byte, stream_end
// event   | out | event_valid / event_stall | kind, payload_byte, entry_first .. run_last (8)
//
// One byte transfer per cycle while byte_stall is low; the parser settles all its state in
// the accepting cycle. A byte gives zero, one or two events; the back end sends one event
// per cycle while event_stall is low, and the event queue (QUEUE_DEPTH records) absorbs
// the second event of a two-event byte; events pass the queue, then the output register.
// Reset (arst_n low) clears parser state, queue pointers and output valid.
// byte_stall rises only when the queue is full; event_stall holds the output register.
module tar_stream_deframer #(
	parameter int QUEUE_DEPTH = tsd_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          stream_end,
	output logic                          event_valid,
	input  logic                          event_stall,
	output logic [tsd_pkg::KIND_W-1:0]    kind,
	output logic [7:0]                    payload_byte,
	output logic                          entry_first,
	output logic                          entry_last,
	output logic [tsd_pkg::SIZE_W-1:0]    entry_size,
	output logic [tsd_pkg::FILES_W-1:0]   files_found,
	output logic [tsd_pkg::BYTES_W-1:0]   bytes_found,
	output logic                          run_last
);

	logic             accept;   // byte transfer this cycle
	logic             full;
	logic             pop;
	tsd_pkg::push_t   push;
	tsd_pkg::q_view_t view;

	assign byte_stall = full;
	assign accept     = byte_valid && !full;

	// front: header decode, size scan, data / pad counting, saturating totals
	tsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.stream_end (stream_end),
		.push       (push)
	);

	// decouples the parser from output backpressure
	tsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (full),
		.view   (view)
	);

	// back: one event per cycle into the output register while event_stall is low
	tsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.view         (view),
		.pop          (pop),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.kind         (kind),
		.payload_byte (payload_byte),
		.entry_first  (entry_first),
		.entry_last   (entry_last),
		.entry_size   (entry_size),
		.files_found  (files_found),
		.bytes_found  (bytes_found),
		.run_last     (run_last)
	);

endmodule

// ----- hdl/tsd_checker.sv -----
module tsd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          event_valid,
	input logic                          event_stall,
	input logic [tsd_pkg::KIND_W-1:0]    kind,
	input logic [7:0]                    payload_byte,
	input logic                          entry_first,
	input logic                          entry_last,
	input logic [tsd_pkg::SIZE_W-1:0]    entry_size,
	input logic                          run_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_stall |=> event_valid && $stable(kind) &&
		$stable(payload_byte) && $stable(entry_size) && $stable(run_last))
		else $error("stalled event changed");

	a_payload_only: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && kind != tsd_pkg::KIND_PAYLOAD |->
		!entry_first && !entry_last && payload_byte == 8'h00)
		else $error("payload marks on a non-payload event");

	a_size_only: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && kind != tsd_pkg::KIND_HEADER |-> entry_size == '0)
		else $error("entry size on a non-header event");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && (kind == tsd_pkg::KIND_DONE || kind == tsd_pkg::KIND_TRUNC ||
		kind == tsd_pkg::KIND_NOENT) |-> run_last)
		else $error("final report not last of its byte");

endmodule

bind tar_stream_deframer tsd_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.event_valid  (event_valid),
	.event_stall  (event_stall),
	.kind         (kind),
	.payload_byte (payload_byte),
	.entry_first  (entry_first),
	.entry_last   (entry_last),
	.entry_size   (entry_size),
	.run_last     (run_last)
);

// ----- test/tar_stream_deframer_tb.sv -----
`timescale 1ns / 100ps

// one output event, as the parser should produce it
typedef struct packed {
	logic [tsd_pkg::KIND_W-1:0]  kind;
	logic [7:0]                  payload_byte;
	logic                        entry_first;
	logic                        entry_last;
	logic [tsd_pkg::SIZE_W-1:0]  entry_size;
	logic [tsd_pkg::FILES_W-1:0] files_found;
	logic [tsd_pkg::BYTES_W-1:0] bytes_found;
	logic                        run_last;
} tar_event_t;

// Tracks the tar parse of every byte transfer and holds the events still owed.
class tar_event_ledger;
	logic [1:0]                  parse_phase;
	logic [tsd_pkg::POS_W-1:0]   blk_pos;
	logic [tsd_pkg::SIZE_W-1:0]  size_acc;
	logic [1:0]                  scan;
	logic [3:0]                  flags;
	logic [tsd_pkg::SIZE_W-1:0]  data_left;
	logic [tsd_pkg::POS_W-1:0]   pad_left;
	logic                        regular;
	logic [tsd_pkg::FILES_W-1:0] nfiles;
	logic [tsd_pkg::BYTES_W-1:0] nbytes;
	tar_event_t                  expected[$];
	int                          fails;

	function new();
		fails = 0;
		restart();
	endfunction

	function void restart();
		parse_phase = tsd_pkg::PH_HEADER;
		blk_pos     = '0;
		size_acc    = '0;
		scan        = tsd_pkg::SCAN_NONE;
		flags       = '0;
		data_left   = '0;
		pad_left    = '0;
		regular     = 1'b0;
		nfiles      = '0;
		nbytes      = '0;
	endfunction

	function int outstanding();
		return expected.size();
	endfunction

	function tar_event_t make_event(logic [tsd_pkg::KIND_W-1:0] k, logic [7:0] pb, logic f,
			logic l, logic [tsd_pkg::SIZE_W-1:0] sz);
		tar_event_t ev;
		ev.kind         = k;
		ev.payload_byte = pb;
		ev.entry_first  = f;
		ev.entry_last   = l;
		ev.entry_size   = sz;
		ev.files_found  = nfiles;
		ev.bytes_found  = nbytes;
		ev.run_last     = 1'b0;
		return ev;
	endfunction

	// saturating file and byte totals
	function void tally(logic [tsd_pkg::SIZE_W-1:0] sz);
		logic [tsd_pkg::BYTES_W:0] sum;
		if (~&nfiles)
			nfiles = nfiles + 1'b1;
		sum = {1'b0, nbytes} + (tsd_pkg::BYTES_W+1)'(sz);
		nbytes = sum[tsd_pkg::BYTES_W] ? '1 : sum[tsd_pkg::BYTES_W-1:0];
	endfunction

	function void note_byte(logic [7:0] b, logic last_of_stream);
		logic [tsd_pkg::POS_W-1:0] pos;
		logic                      final_sent;
		logic                      last;
		tar_event_t                burst[$];
		tar_event_t                ev;
		final_sent = 1'b0;
		if (parse_phase == tsd_pkg::PH_HEADER) begin
			pos = blk_pos;
			if (pos == 0) begin
				size_acc = '0;
				scan     = tsd_pkg::SCAN_NONE;
				flags    = '0;
			end
			if (b != 8'h00) begin
				flags[tsd_pkg::FL_NONZERO] = 1'b1;
				if (pos == 0)
					flags[tsd_pkg::FL_NAME] = 1'b1;
				if (pos == tsd_pkg::OFS_PREFIX)
					flags[tsd_pkg::FL_PREFIX] = 1'b1;
			end
			if (pos == tsd_pkg::OFS_TYPE && (b == 8'h00 || b == tsd_pkg::CHAR_ZERO))
				flags[tsd_pkg::FL_REGULAR] = 1'b1;
			// octal size: first run of digits, NUL ends the field
			if (pos >= tsd_pkg::OFS_SIZE && pos < tsd_pkg::OFS_SIZE_END &&
					scan != tsd_pkg::SCAN_OVER) begin
				if (b == 8'h00) begin
					scan = tsd_pkg::SCAN_OVER;
				end else if (b >= tsd_pkg::CHAR_ZERO && b <= tsd_pkg::CHAR_SEVEN) begin
					size_acc = {size_acc[tsd_pkg::SIZE_W-4:0], 3'(b - tsd_pkg::CHAR_ZERO)};
					scan     = tsd_pkg::SCAN_DIGITS;
				end else if (scan == tsd_pkg::SCAN_DIGITS) begin
					scan = tsd_pkg::SCAN_OVER;
				end
			end
			if (pos == tsd_pkg::POS_LAST) begin
				blk_pos = '0;
				if (!flags[tsd_pkg::FL_NONZERO]) begin
					burst.push_back(make_event(nfiles != 0 ? tsd_pkg::KIND_DONE :
						tsd_pkg::KIND_NOENT, 8'h00, 1'b0, 1'b0, '0));
					final_sent  = 1'b1;
					parse_phase = tsd_pkg::PH_DONE;
				end else begin
					regular = (flags[tsd_pkg::FL_NAME] | flags[tsd_pkg::FL_PREFIX]) &
						flags[tsd_pkg::FL_REGULAR];
					if (regular)
						burst.push_back(make_event(tsd_pkg::KIND_HEADER, 8'h00, 1'b0, 1'b0,
							size_acc));
					if (size_acc == 0) begin
						if (regular)
							tally('0);
					end else begin
						data_left   = size_acc;
						pad_left    = tsd_pkg::POS_W'(10'd512 -
							{1'b0, size_acc[tsd_pkg::POS_W-1:0]});
						parse_phase = tsd_pkg::PH_DATA;
					end
				end
			end else begin
				blk_pos = pos + 1'b1;
			end
		end else if (parse_phase == tsd_pkg::PH_DATA) begin
			last = (data_left <= 1);
			if (regular)
				burst.push_back(make_event(tsd_pkg::KIND_PAYLOAD, b, data_left == size_acc,
					last, '0));
			if (last) begin
				data_left = '0;
				if (regular)
					tally(size_acc);
				blk_pos     = '0;
				parse_phase = (pad_left != 0) ? tsd_pkg::PH_PAD : tsd_pkg::PH_HEADER;
			end else begin
				data_left = data_left - 1'b1;
			end
		end else if (parse_phase == tsd_pkg::PH_PAD) begin
			if (pad_left <= 1) begin
				pad_left    = '0;
				blk_pos     = '0;
				parse_phase = tsd_pkg::PH_HEADER;
			end else begin
				pad_left = pad_left - 1'b1;
			end
		end

		if (last_of_stream) begin
			if (!final_sent && parse_phase != tsd_pkg::PH_DONE)
				burst.push_back(make_event(parse_phase == tsd_pkg::PH_DATA ?
					tsd_pkg::KIND_TRUNC :
					(nfiles != 0 ? tsd_pkg::KIND_DONE : tsd_pkg::KIND_NOENT),
					8'h00, 1'b0, 1'b0, '0));
			restart();
		end

		foreach (burst[i]) begin
			ev = burst[i];
			ev.run_last = (i == burst.size() - 1);
			expected.push_back(ev);
		end
	endfunction

	function void compare(string field, logic [tsd_pkg::BYTES_W-1:0] want,
			logic [tsd_pkg::BYTES_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			fails++;
		end
	endfunction

	function void check_event(tar_event_t got);
		tar_event_t want;
		if (expected.size() == 0) begin
			$error("kind: expected no event, got 0x%0h", got.kind);
			fails++;
			return;
		end
		want = expected.pop_front();
		compare("kind", want.kind, got.kind);
		compare("payload_byte", want.payload_byte, got.payload_byte);
		compare("entry_first", want.entry_first, got.entry_first);
		compare("entry_last", want.entry_last, got.entry_last);
		compare("entry_size", want.entry_size, got.entry_size);
		compare("files_found", want.files_found, got.files_found);
		compare("bytes_found", want.bytes_found, got.bytes_found);
		compare("run_last", want.run_last, got.run_last);
	endfunction
endclass

module tar_stream_deframer_tb;

	localparam int HOLD_CYCLES   = 400;   // long output hold to fill the event queue
	localparam int QUIET_LIMIT   = 4000;  // cycles with no transfer before giving up
	localparam int TAIL_CYCLES   = 8;     // idle cycles after the last drain before the final check
	localparam int NOISE_BYTES   = 60;    // stream cut inside its first header
	localparam int TRAILER_BYTES = 3;     // bytes after the zero block
	localparam int FILE_BYTES    = 280;   // payload of the regular entry
	localparam int HOLD_AT       = tsd_pkg::BLOCK_BYTES + 8;   // inside that payload

	// type flag values used in headers
	localparam logic [7:0] TYPE_REG_NUL = 8'h00;
	localparam logic [7:0] TYPE_REG     = tsd_pkg::CHAR_ZERO;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	// layouts of the octal size field
	typedef enum int {SZ_PLAIN, SZ_FULL, SZ_BLANKS, SZ_JUNK, SZ_NONE} size_style_e;

	logic                         clk;
	logic                         arst_n;
	logic                         byte_valid;
	logic                         byte_stall;
	logic [7:0]                   data_byte;
	logic                         stream_end;
	logic                         event_valid;
	logic                         event_stall;
	logic [tsd_pkg::KIND_W-1:0]   kind;
	logic [7:0]                   payload_byte;
	logic                         entry_first;
	logic                         entry_last;
	logic [tsd_pkg::SIZE_W-1:0]   entry_size;
	logic [tsd_pkg::FILES_W-1:0]  files_found;
	logic [tsd_pkg::BYTES_W-1:0]  bytes_found;
	logic                         run_last;

	tar_event_ledger ledger = new();
	tar_event_t      seen;

	int tx_idle_pct  = 19;
	int rx_idle_pct  = 80;
	int hold_asks    = 0;
	int quiet_cycles = 0;

	logic [7:0] blk [0:tsd_pkg::BLOCK_BYTES-1];   // header block under construction
	logic [7:0] stream_q[$];                       // bytes of the stream to send

	tar_stream_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.stream_end   (stream_end),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.kind         (kind),
		.payload_byte (payload_byte),
		.entry_first  (entry_first),
		.entry_last   (entry_last),
		.entry_size   (entry_size),
		.files_found  (files_found),
		.bytes_found  (bytes_found),
		.run_last     (run_last)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// event side: stall changes at the falling edge; a long hold, when asked,
	// is counted out here while the byte side keeps offering transfers
	initial begin
		int holds_done;
		holds_done  = 0;
		event_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asks != holds_done) begin
				holds_done++;
				event_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			event_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// every accepted event is checked against the oldest one owed
	always @(posedge clk) begin
		if (arst_n && event_valid && !event_stall) begin
			seen.kind         = kind;
			seen.payload_byte = payload_byte;
			seen.entry_first  = entry_first;
			seen.entry_last   = entry_last;
			seen.entry_size   = entry_size;
			seen.files_found  = files_found;
			seen.bytes_found  = bytes_found;
			seen.run_last     = run_last;
			ledger.check_event(seen);
		end
	end

	// watchdog: a run of cycles with no transfer on either side means a hang
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (event_valid && !event_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// one byte transfer; called and returns at a falling edge
	task automatic push_byte(input logic [7:0] value, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		data_byte  <= value;
		stream_end <= last;
		do
			@(posedge clk);
		while (byte_stall);
		ledger.note_byte(value, last);
		@(negedge clk);
	endtask

	// send the queued stream, stream_end on its final byte
	task automatic send_stream(input int hold_at);
		for (int i = 0; i < stream_q.size(); i++) begin
			if (i == hold_at)
				hold_asks++;
			push_byte(stream_q[i], i == stream_q.size() - 1);
		end
		stream_q.delete();
	endtask

	// pause the byte side until every owed event has come out
	task automatic drain();
		byte_valid <= 1'b0;
		while (ledger.outstanding() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] non_octal();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c >= tsd_pkg::CHAR_ZERO && c <= tsd_pkg::CHAR_SEVEN);
		return c;
	endfunction

	task automatic add_header(input bit named, input bit prefixed, input logic [7:0] tflag,
			input logic [tsd_pkg::SIZE_W-1:0] size, input size_style_e style);
		logic [2:0]  dig [0:11];
		int          first_nz;
		int          p;
		size_style_e sty;
		for (int i = 0; i < tsd_pkg::BLOCK_BYTES; i++)
			blk[i] = ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom);
		blk[100]                 = tsd_pkg::CHAR_ZERO;   // block stays non-zero with no name
		blk[0]                   = named ? 8'($urandom_range(1, 255)) : 8'h00;
		blk[tsd_pkg::OFS_PREFIX] = prefixed ? 8'($urandom_range(1, 255)) : 8'h00;
		blk[tsd_pkg::OFS_TYPE]   = tflag;
		for (int k = 0; k < 12; k++)
			dig[k] = size[tsd_pkg::SIZE_W-1-3*k -: 3];
		first_nz = 11;
		for (int k = 11; k >= 0; k--)
			if (dig[k] != 0)
				first_nz = k;
		sty = style;
		if ((sty == SZ_PLAIN && dig[0] != 0) ||
				((sty == SZ_BLANKS || sty == SZ_JUNK) && first_nz < 2))
			sty = SZ_FULL;
		case (sty)
			SZ_PLAIN: begin
				for (int k = 0; k < 11; k++)
					blk[tsd_pkg::OFS_SIZE+k] = tsd_pkg::CHAR_ZERO + 8'(dig[k+1]);
				blk[tsd_pkg::OFS_SIZE+11] = 8'h00;
			end
			SZ_FULL: begin
				for (int k = 0; k < 12; k++)
					blk[tsd_pkg::OFS_SIZE+k] = tsd_pkg::CHAR_ZERO + 8'(dig[k]);
			end
			SZ_BLANKS: begin
				// right-aligned digits behind leading blanks
				for (int k = 0; k < 11; k++)
					blk[tsd_pkg::OFS_SIZE+k] = (k < first_nz - 1) ? CHAR_SPACE :
						tsd_pkg::CHAR_ZERO + 8'(dig[k+1]);
				blk[tsd_pkg::OFS_SIZE+11] = $urandom_range(1) ? CHAR_SPACE : 8'h00;
			end
			SZ_JUNK: begin
				// junk lead, the digits, a non-octal stop, then digits to be ignored
				p = int'(tsd_pkg::OFS_SIZE);
				blk[p] = non_octal();
				p = p + 1;
				for (int k = first_nz; k < 12; k++) begin
					blk[p] = tsd_pkg::CHAR_ZERO + 8'(dig[k]);
					p = p + 1;
				end
				blk[p] = non_octal();
				p = p + 1;
				while (p < int'(tsd_pkg::OFS_SIZE_END)) begin
					blk[p] = tsd_pkg::CHAR_ZERO + 8'($urandom_range(7));
					p = p + 1;
				end
			end
			default: begin
				// no digit at all: blanks only, or a NUL ahead of digits
				for (int k = 0; k < 12; k++)
					blk[tsd_pkg::OFS_SIZE+k] = tsd_pkg::CHAR_ZERO + 8'($urandom_range(7));
				if ($urandom_range(1))
					for (int k = 0; k < 12; k++)
						blk[tsd_pkg::OFS_SIZE+k] = CHAR_SPACE;
				else
					blk[tsd_pkg::OFS_SIZE] = 8'h00;
			end
		endcase
		for (int i = 0; i < tsd_pkg::BLOCK_BYTES; i++)
			stream_q.push_back(blk[i]);
	endtask

	task automatic add_zero_block();
		repeat (tsd_pkg::BLOCK_BYTES)
			stream_q.push_back(8'h00);
	endtask

	task automatic add_noise(input int count);
		repeat (count)
			stream_q.push_back(8'($urandom));
	endtask

	initial begin
		int          pick;
		bit          named;
		bit          prefixed;
		logic [7:0]  tflag;
		size_style_e style;
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		data_byte  = 8'h00;
		stream_end = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// slow receiver: lone end bytes, then a stream cut inside its first header
		tx_idle_pct = 19;
		rx_idle_pct = 80;
		stream_q.push_back(8'h00);
		send_stream(-1);
		stream_q.push_back(8'hFF);
		send_stream(-1);
		add_noise(NOISE_BYTES);
		send_stream(-1);
		drain();

		// slow sender: empty archive; bytes after the zero block give nothing
		tx_idle_pct = 80;
		rx_idle_pct = 19;
		add_zero_block();
		add_noise(TRAILER_BYTES);
		send_stream(-1);
		drain();

		// no idling: one regular file whose last payload byte ends the stream, so the
		// payload and the done report come together; a long output hold inside the
		// payload fills the queue and stalls the bytes
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		pick     = $urandom_range(2);
		named    = (pick != 1);
		prefixed = (pick != 0);
		tflag    = $urandom_range(1) ? TYPE_REG : TYPE_REG_NUL;
		style    = size_style_e'($urandom_range(SZ_JUNK));
		add_header(named, prefixed, tflag, tsd_pkg::SIZE_W'(FILE_BYTES), style);
		add_noise(FILE_BYTES);
		send_stream(HOLD_AT);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (ledger.fails == 0 && ledger.outstanding() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
